[rtl/dvrt_pkg.sv]
// shared types and constants for the distance vector route table
`default_nettype none
package dvrt_pkg;
	localparam int MaxPorts = 16;
	localparam int MaxNodes = 64;
	localparam int PortW = 4;
	localparam int NodeW = 6;
	localparam int CostW = 16;
	localparam int TimeW = 32;
	localparam int ApW = 5;
	localparam int InW = 104;
	localparam int OutW = 40;

	localparam logic [1:0] CfgActivePorts = 2'd0;
	localparam logic [1:0] CfgTimeout = 2'd1;
	localparam logic [1:0] CfgInfinity = 2'd2;

	localparam logic [1:0] ActReply = 2'd0;
	localparam logic [1:0] ActVector = 2'd1;
	localparam logic [1:0] ActTick = 2'd2;
	localparam logic [1:0] ActAdv = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_ADV,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture input item
		logic exec;      // reply / vector update
		logic scan_step; // expiry of one port
		logic adv_step;  // look at one route
		logic clr_cnt;
		logic emit_single;
		logic emit_adv;
		logic emit_final_empty;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] action;
		logic scan_done;
		logic adv_ok;    // advertise port has a neighbor
		logic adv_hit;   // current route valid
		logic adv_more;  // a valid route follows the current one
		logic adv_last_idx;
		logic adv_any;   // a route was emitted
	} sts_t;
endpackage
`default_nettype wire

[rtl/dvrt_ctrl.sv]
// controller state machine of the route table
`default_nettype none
module dvrt_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_fire,
	input  wire logic out_busy,
	input  wire dvrt_pkg::sts_t sts,
	output dvrt_pkg::cmd_t cmd,
	output logic idle
);
	import dvrt_pkg::*;
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_EXEC;
			ST_EXEC: begin
				if (!out_busy) begin
					unique case (sts.action)
						ActTick: state_d = ST_SCAN;
						ActAdv: state_d = ST_ADV;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCAN: if (sts.scan_done) state_d = ST_OUT;
			ST_ADV: begin
				if (!out_busy) begin
					if (!sts.adv_ok || sts.adv_last_idx && !sts.adv_hit && !sts.adv_any)
						state_d = ST_IDLE;
					else if (sts.adv_hit && !sts.adv_more) state_d = ST_IDLE;
					else if (!sts.adv_hit && sts.adv_last_idx) state_d = ST_IDLE;
				end
			end
			ST_OUT: if (!out_busy) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		idle = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: cmd.load = in_fire;
			ST_EXEC: begin
				if (!out_busy) begin
					cmd.clr_cnt = 1'b1;
					if (sts.action == ActReply || sts.action == ActVector) begin
						cmd.exec = 1'b1;
						cmd.emit_single = 1'b1;
					end
				end
			end
			ST_SCAN: cmd.scan_step = 1'b1;
			ST_ADV: begin
				if (!out_busy) begin
					cmd.adv_step = 1'b1;
					if (!sts.adv_ok) cmd.emit_final_empty = 1'b1;
					else if (sts.adv_hit) cmd.emit_adv = 1'b1;
					else if (sts.adv_last_idx && !sts.adv_any) cmd.emit_final_empty = 1'b1;
				end
			end
			ST_OUT: cmd.emit_single = !out_busy;
			default: cmd = '0;
		endcase
	end
endmodule
`default_nettype wire

[rtl/dvrt_data.sv]
// tables, arithmetic and result register of the route table
`default_nettype none
module dvrt_data (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [dvrt_pkg::InW-1:0] in_item,
	input  wire logic cfg_we,
	input  wire logic [1:0] cfg_idx,
	input  wire logic [dvrt_pkg::TimeW-1:0] cfg_data,
	input  wire dvrt_pkg::cmd_t cmd,
	output dvrt_pkg::sts_t sts,
	output logic out_busy,
	output logic out_v,
	input  wire logic out_rdy,
	output logic [dvrt_pkg::OutW-1:0] out_item
);
	import dvrt_pkg::*;

	logic [ApW-1:0] active_q;
	logic [TimeW-1:0] tmo_q;
	logic [CostW-1:0] inf_q;

	logic [1:0] act_q;
	logic [PortW-1:0] port_q;
	logic [NodeW-1:0] src_q, dst_q;
	logic [CostW-1:0] cost_q;
	logic [TimeW-1:0] now_q, sent_q;
	logic last_q;

	logic [MaxPorts-1:0] nv_q;
	logic [NodeW-1:0] nid_q [MaxPorts];
	logic [TimeW-1:0] nseen_q [MaxPorts];
	logic [CostW-1:0] nrtt_q [MaxPorts];
	logic [MaxNodes-1:0] rv_q;
	logic pchg_q;

	logic [PortW:0] scan_q;
	logic [NodeW:0] idx_q;
	logic [ApW-1:0] rem_q;
	logic any_q;

	// route entries: next hop above cost, read through a register ahead of use
	logic [NodeW+CostW-1:0] route_mem [MaxNodes];
	logic [NodeW+CostW-1:0] rd_q;
	logic [CostW-1:0] rd_cost;
	logic [NodeW-1:0] rd_hop;
	assign rd_cost = rd_q[CostW-1:0];
	assign rd_hop = rd_q[NodeW+CostW-1:CostW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ApW'(16);
			tmo_q <= TimeW'(15000);
			inf_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CfgActivePorts: active_q <= cfg_data[ApW-1:0];
				CfgTimeout: tmo_q <= cfg_data;
				CfgInfinity: inf_q <= cfg_data[CostW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_item[1:0];
			port_q <= in_item[5:2];
			src_q <= in_item[11:6];
			dst_q <= in_item[17:12];
			cost_q <= in_item[33:18];
			now_q <= in_item[65:34];
			sent_q <= in_item[97:66];
			last_q <= in_item[98];
		end
	end

	// reply and vector arithmetic
	logic [CostW-1:0] rtt, direct, total;
	logic [CostW:0] sum;
	logic nv_p, rv_s, rv_d;
	logic rep_upd, vec_chg, vec_new;
	always_comb begin
		rtt = now_q[CostW-1:0] - sent_q[CostW-1:0];
		direct = (rtt > inf_q) ? inf_q : rtt;
		nv_p = nv_q[port_q];
		rv_s = rv_q[src_q];
		rv_d = rv_q[dst_q];
		sum = {1'b0, nrtt_q[port_q]} + {1'b0, cost_q};
		total = (cost_q >= inf_q || sum > {1'b0, inf_q}) ? inf_q : sum[CostW-1:0];
		rep_upd = !nv_p || !rv_s || rd_cost != direct;
		vec_new = !rv_d || rd_cost > total;
		vec_chg = nv_p && (vec_new || rd_hop == src_q && rd_cost != total);
	end

	// expiry of one port per cycle
	logic [PortW-1:0] sp;
	logic expire;
	always_comb begin
		sp = scan_q[PortW-1:0];
		expire = nv_q[sp] && (now_q - nseen_q[sp]) > tmo_q;
	end

	logic [NodeW-1:0] ai, nidp;
	logic [MaxNodes-1:0] above;
	always_comb begin
		ai = idx_q[NodeW-1:0];
		nidp = nid_q[port_q];
		above = rv_q & ~((MaxNodes'(2) << ai) - MaxNodes'(1));
		sts.action = act_q;
		sts.scan_done = scan_q >= {1'b0, (active_q > ApW'(MaxPorts)) ? PortW'(0) : active_q[PortW-1:0]}
			&& !(active_q >= ApW'(MaxPorts) && !scan_q[PortW]) ;
		sts.adv_ok = nv_p;
		sts.adv_hit = rv_q[ai];
		sts.adv_more = |above;
		sts.adv_last_idx = (ai == NodeW'(MaxNodes-1));
		sts.adv_any = any_q;
	end

	// one write and one registered read per cycle
	logic rt_we, rd_en;
	logic [NodeW-1:0] rt_addr, rd_addr;
	logic [NodeW+CostW-1:0] rt_wdata;
	always_comb begin
		rt_we = cmd.exec && ((act_q == ActReply) ? rep_upd : vec_chg);
		rt_addr = (act_q == ActReply) ? src_q : dst_q;
		rt_wdata = {src_q, (act_q == ActReply) ? direct : total};
		rd_en = cmd.load || cmd.clr_cnt || cmd.adv_step;
		if (cmd.load) rd_addr = (in_item[1:0] == ActVector) ? in_item[17:12] : in_item[11:6];
		else if (cmd.adv_step) rd_addr = ai + NodeW'(1);
		else rd_addr = '0;
	end

	always_ff @(posedge clk) begin
		if (rt_we) route_mem[rt_addr] <= rt_wdata;
		if (rd_en) rd_q <= route_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_q <= '0;
			rv_q <= '0;
			pchg_q <= 1'b0;
			scan_q <= '0;
			idx_q <= '0;
			rem_q <= '0;
			any_q <= 1'b0;
		end else begin
			if (cmd.clr_cnt) begin
				scan_q <= '0;
				idx_q <= '0;
				rem_q <= '0;
				any_q <= 1'b0;
			end
			if (cmd.exec && act_q == ActReply) begin
				nv_q[port_q] <= 1'b1;
				if (rep_upd) rv_q[src_q] <= 1'b1;
			end
			if (cmd.exec && act_q == ActVector) begin
				if (nv_p && vec_new) rv_q[dst_q] <= 1'b1;
				if (last_q) pchg_q <= 1'b0;
				else if (vec_chg) pchg_q <= 1'b1;
			end
			if (cmd.scan_step && !sts.scan_done) begin
				scan_q <= scan_q + 1'b1;
				if (expire) begin
					nv_q[sp] <= 1'b0;
					rv_q[nid_q[sp]] <= 1'b0;
					rem_q <= rem_q + 1'b1;
				end
			end
			if (cmd.adv_step) begin
				idx_q <= idx_q + 1'b1;
				if (cmd.emit_adv) any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && act_q == ActReply) begin
			if (!nv_p) nid_q[port_q] <= src_q;
			nseen_q[port_q] <= now_q;
			nrtt_q[port_q] <= rtt;
		end
	end

	// result register
	logic ov_q;
	logic [OutW-1:0] od_q, od_d;
	logic [CostW-1:0] acost;
	logic emit;
	always_comb begin
		acost = (rd_hop == nidp) ? inf_q : rd_cost;
		emit = cmd.emit_single || cmd.emit_adv || cmd.emit_final_empty;
		od_d = '0;
		if (cmd.emit_adv) begin
			od_d[6] = 1'b1;
			od_d[12:7] = nidp;
			od_d[18:13] = ai;
			od_d[34:19] = acost;
			od_d[36] = !sts.adv_more;
		end else begin
			od_d[36] = 1'b1;
			if (cmd.emit_single) begin
				if (act_q == ActTick) od_d[5:1] = rem_q;
				else if (act_q == ActReply) od_d[0] = rep_upd;
				else od_d[0] = last_q && (pchg_q || vec_chg);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			od_q <= '0;
		end else begin
			ov_q <= emit || (ov_q && !out_rdy);
			if (emit) od_q <= od_d;
		end
	end
	assign out_v = ov_q;
	assign out_item = od_q;
	assign out_busy = ov_q && !out_rdy;

	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_single && cmd.emit_adv)) else $error("two results at once");
	a_scan_lim: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= (PortW+1)'(MaxPorts)) else $error("scan overrun");
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= ApW'(MaxPorts)) else $error("removed count overrun");
endmodule
`default_nettype wire

[rtl/distance_vector_route_table.sv]
// top level of the distance vector route table
// One item is in work at a time and s_tready is high only while the block is idle. For reply and
// vector entries the route entry is read at accept and updated in the EXEC state. An expiry tick
// checks one port per cycle, min(active_ports,16) ports in all. An advertise steps through the
// route entries in order up to the last valid one, giving one result per valid route, or one
// empty final result when the port has no neighbor or no route is valid. Routes sit in a RAM
// with a registered read, addressed ahead of use. A result waiting on m_tready stalls the EXEC,
// ADV and OUT states; an item only completes its update once the previous result has been taken.
`default_nettype none
module distance_vector_route_table (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	// action, port, sender id, dest_id, cost, now, sent_time (lowest first)
	input  wire logic [dvrt_pkg::InW-1:0] s_tdata,
	input  wire logic s_tlast,
	output logic m_tvalid,
	input  wire logic m_tready,
	// update_needed, removed_count, adv_valid, adv_neighbor, adv_dest, adv_cost
	output logic [dvrt_pkg::OutW-1:0] m_tdata,
	output logic m_tlast,
	input  wire logic cfg_we,
	input  wire logic [1:0] cfg_addr,
	input  wire logic [31:0] cfg_data
);
	import dvrt_pkg::*;
	cmd_t cmd;
	sts_t sts;
	logic busy, idle, ov;
	logic [OutW-1:0] od;

	assign s_tready = idle;

	dvrt_ctrl u_ctrl (.clk, .arst_n, .in_fire(s_tvalid && s_tready), .out_busy(busy),
		.sts, .cmd, .idle);
	dvrt_data u_data (.clk, .arst_n, .in_item({5'b0, s_tlast, s_tdata[97:0]}), .cfg_we,
		.cfg_idx(cfg_addr), .cfg_data, .cmd, .sts, .out_busy(busy), .out_v(ov),
		.out_rdy(m_tready), .out_item(od));

	assign m_tvalid = ov;
	assign m_tdata = {5'b0, od[34:0]};
	assign m_tlast = od[36];
endmodule
`default_nettype wire
